/* src/pwd_pkg.sv */
// shared constants, codes and controller/datapath structs for the work dispatcher
// no dependencies; every other file but pwd_ram imports this package
`timescale 1ns / 1ps
`default_nettype none

package pwd_pkg;

    localparam int NUM_WORKERS  = 16;
    localparam int QUEUE_DEPTH  = 64;
    localparam int HANDLE_WIDTH = 16;
    localparam int MAX_RESULTS  = 16;

    // fixed field widths of the request and result channels
    localparam int KIND_W = 3;
    localparam int ID_W   = 5;
    localparam int KEY_W  = 32;
    localparam int ACT_W  = 3;
    localparam int FILL_W = 7;

    localparam int QA_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int N_W     = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W = KEY_W + HANDLE_WIDTH;

    localparam logic [KIND_W-1:0] KIND_SUBMIT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DIST   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FORK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FINISH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HALT   = 3'd4;

    localparam logic [ACT_W-1:0] ACT_NOTHING = 3'd0;
    localparam logic [ACT_W-1:0] ACT_QUEUED  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ASSIGN  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_QUIT    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_HALTED  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DROPPED = 3'd5;

    // payload source for a result
    localparam logic [1:0] PAY_ZERO = 2'd0;
    localparam logic [1:0] PAY_IN   = 2'd1;
    localparam logic [1:0] PAY_RAM  = 2'd2;

    typedef struct packed {
        logic             load_in;
        logic             rd_en;
        logic             rd_tail;
        logic             ptr_load;
        logic             shift;
        logic             ins_write;
        logic             pop;
        logic             busy_set;
        logic             busy_clear;
        logic             tgt_sender;
        logic             stop_set;
        logic             n_clear;
        logic             n_inc;
        logic             emit;
        logic             with_target;
        logic             last;
        logic [ACT_W-1:0] act;
        logic [1:0]       pay;
    } pwd_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              stopped;
        logic              bad_sender;
        logic              q_empty;
        logic              q_full;
        logic              idle_any;
        logic              busy_after_clear;
        logic              ptr_zero;
        logic              worse;
        logic              out_free;
        logic              more;
    } pwd_stat_t;

endpackage

`default_nettype wire

/* src/pwd_if.sv */
// request and result channel interfaces of the work dispatcher
// depends on pwd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pwd_in_if;
    import pwd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [ID_W-1:0]         sender_id;
    logic [KEY_W-1:0]        job_key;
    logic [HANDLE_WIDTH-1:0] job_handle;

    modport source (output valid, kind, sender_id, job_key, job_handle, input ready);
    modport sink   (input valid, kind, sender_id, job_key, job_handle, output ready);
endinterface

interface pwd_out_if;
    import pwd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [ID_W-1:0]         target_worker;
    logic [KEY_W-1:0]        out_key;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic [FILL_W-1:0]       queue_fill;
    logic                    last;

    modport source (output valid, action, target_worker, out_key, out_handle, queue_fill,
                    last, input ready);
    modport sink   (input valid, action, target_worker, out_key, out_handle, queue_fill,
                    last, output ready);
endinterface

`default_nettype wire

/* src/pwd_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/pwd_datapath.sv */
// dispatcher datapath: request registers, worker busy bits, sorted job queue
// in pwd_ram, queue count, insertion pointer and result register
// depends on pwd_pkg and pwd_ram
`timescale 1ns / 1ps
`default_nettype none

module pwd_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pwd_pkg::pwd_cmd_t                cmd,
    output      pwd_pkg::pwd_stat_t               stat,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_wdata,
    input  wire logic [pwd_pkg::KIND_W-1:0]       in_kind,
    input  wire logic [pwd_pkg::ID_W-1:0]         in_sender_id,
    input  wire logic [pwd_pkg::KEY_W-1:0]        in_job_key,
    input  wire logic [pwd_pkg::HANDLE_WIDTH-1:0] in_job_handle,
    output      logic                             out_valid,
    input  wire logic                             out_ready,
    output      logic [pwd_pkg::ACT_W-1:0]        out_action,
    output      logic [pwd_pkg::ID_W-1:0]         out_target_worker,
    output      logic [pwd_pkg::KEY_W-1:0]        out_key,
    output      logic [pwd_pkg::HANDLE_WIDTH-1:0] out_handle,
    output      logic [pwd_pkg::FILL_W-1:0]       out_queue_fill,
    output      logic                             out_last
);
    import pwd_pkg::*;

    logic                    serve_order_reg;
    logic [NUM_WORKERS-1:0]  busy_reg, busy_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    stopped_reg;
    logic [CNT_W-1:0]        ptr_reg;
    logic [N_W-1:0]          n_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [ID_W-1:0]         sender_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [HANDLE_WIDTH-1:0] handle_reg;

    logic                    out_valid_reg;
    logic [ACT_W-1:0]        action_reg;
    logic [ID_W-1:0]         target_reg;
    logic [KEY_W-1:0]        okey_reg;
    logic [HANDLE_WIDTH-1:0] ohandle_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic                    last_reg;

    logic                    ram_we, ram_re;
    logic [QA_W-1:0]         ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
    logic [KEY_W-1:0]        rd_key;
    logic [HANDLE_WIDTH-1:0] rd_handle;

    logic [ID_W-1:0]         idle_id;
    logic [ID_W-1:0]         tgt;
    logic [NUM_WORKERS-1:0]  tgt_mask, snd_mask;
    logic                    out_free;

    pwd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[ENTRY_W-1:HANDLE_WIDTH];
    assign rd_handle = ram_rdata[HANDLE_WIDTH-1:0];

    // tail read for a pop, otherwise the entry just below the insertion pointer
    assign ram_re    = cmd.rd_en;
    assign ram_raddr = cmd.rd_tail ? QA_W'(count_reg - CNT_W'(1)) : QA_W'(ptr_reg - CNT_W'(1));
    assign ram_we    = cmd.shift | cmd.ins_write;
    assign ram_waddr = QA_W'(ptr_reg);
    assign ram_wdata = cmd.shift ? ram_rdata : {key_reg, handle_reg};

    // lowest idle worker, 0 when all are busy
    always_comb
    begin
        idle_id = '0;
        for (int w = NUM_WORKERS - 1; w >= 0; w--)
        begin
            if (!busy_reg[w])
            begin
                idle_id = ID_W'(w + 1);
            end
        end
    end

    assign tgt = cmd.tgt_sender ? sender_reg : idle_id;

    always_comb
    begin
        for (int w = 0; w < NUM_WORKERS; w++)
        begin
            tgt_mask[w] = (32'(tgt) == 32'(w + 1));
            snd_mask[w] = (32'(sender_reg) == 32'(w + 1));
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.busy_set)
        begin
            busy_next = busy_next | tgt_mask;
        end
        if (cmd.busy_clear)
        begin
            busy_next = busy_next & ~snd_mask;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_write)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.kind             = kind_reg;
        stat.stopped          = stopped_reg;
        stat.bad_sender       = (sender_reg == '0) || (32'(sender_reg) > 32'(NUM_WORKERS));
        stat.q_empty          = (count_reg == '0);
        stat.q_full           = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.idle_any         = !(&busy_reg);
        stat.busy_after_clear = |(busy_reg & ~snd_mask);
        stat.ptr_zero         = (ptr_reg == '0);
        stat.worse            = serve_order_reg ? (key_reg > rd_key) : (key_reg < rd_key);
        stat.out_free         = out_free;
        // another assignment follows this one within the same distribute request
        stat.more             = (32'(n_reg) + 32'd1 < 32'(MAX_RESULTS))
                                && (count_reg > CNT_W'(1))
                                && !(&(busy_reg | tgt_mask));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serve_order_reg <= 1'b0;
            busy_reg        <= '0;
            count_reg       <= '0;
            stopped_reg     <= 1'b0;
            ptr_reg         <= '0;
            n_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                serve_order_reg <= cfg_wdata;
            end
            busy_reg  <= busy_next;
            count_reg <= count_next;
            if (cmd.stop_set)
            begin
                stopped_reg <= 1'b1;
            end
            if (cmd.ptr_load)
            begin
                ptr_reg <= count_reg;
            end
            else if (cmd.shift)
            begin
                ptr_reg <= ptr_reg - CNT_W'(1);
            end
            if (cmd.n_clear)
            begin
                n_reg <= '0;
            end
            else if (cmd.n_inc)
            begin
                n_reg <= n_reg + N_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg   <= in_kind;
            sender_reg <= in_sender_id;
            key_reg    <= in_job_key;
            handle_reg <= in_job_handle;
        end
        if (cmd.emit)
        begin
            action_reg <= cmd.act;
            target_reg <= cmd.with_target ? tgt : '0;
            fill_reg   <= FILL_W'(count_next);
            last_reg   <= cmd.last;
            case (cmd.pay)
                PAY_IN:
                begin
                    okey_reg    <= key_reg;
                    ohandle_reg <= handle_reg;
                end
                PAY_RAM:
                begin
                    okey_reg    <= rd_key;
                    ohandle_reg <= rd_handle;
                end
                default:
                begin
                    okey_reg    <= '0;
                    ohandle_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_action        = action_reg;
    assign out_target_worker = target_reg;
    assign out_key           = okey_reg;
    assign out_handle        = ohandle_reg;
    assign out_queue_fill    = fill_reg;
    assign out_last          = last_reg;

endmodule

`default_nettype wire

/* src/pwd_ctrl.sv */
// dispatcher controller: request decode, insertion walk and pop sequencing
// depends on pwd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pwd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire pwd_pkg::pwd_stat_t stat,
    output      pwd_pkg::pwd_cmd_t  cmd
);
    import pwd_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_INS_RD   = 3'd2;
    localparam logic [2:0] S_INS_CMP  = 3'd3;
    localparam logic [2:0] S_INS_WR   = 3'd4;
    localparam logic [2:0] S_POP_RD   = 3'd5;
    localparam logic [2:0] S_POP_EMIT = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.out_free)
                begin
                    // single-result branches by default
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.act    = ACT_NOTHING;
                    cmd.pay    = PAY_ZERO;
                    state_next = S_IDLE;
                    if (!stat.stopped)
                    begin
                        case (stat.kind)
                            KIND_SUBMIT:
                            begin
                                if (stat.q_full)
                                begin
                                    cmd.act = ACT_DROPPED;
                                    cmd.pay = PAY_IN;
                                end
                                else
                                begin
                                    cmd.emit     = 1'b0;
                                    cmd.ptr_load = 1'b1;
                                    state_next   = S_INS_RD;
                                end
                            end
                            KIND_DIST:
                            begin
                                cmd.n_clear = 1'b1;
                                if (!stat.q_empty && stat.idle_any)
                                begin
                                    cmd.emit   = 1'b0;
                                    state_next = S_POP_RD;
                                end
                            end
                            KIND_FORK:
                            begin
                                if (stat.idle_any)
                                begin
                                    cmd.busy_set    = 1'b1;
                                    cmd.with_target = 1'b1;
                                    cmd.act         = ACT_ASSIGN;
                                    cmd.pay         = PAY_IN;
                                end
                                else if (stat.q_full)
                                begin
                                    cmd.act = ACT_DROPPED;
                                    cmd.pay = PAY_IN;
                                end
                                else
                                begin
                                    cmd.emit     = 1'b0;
                                    cmd.ptr_load = 1'b1;
                                    state_next   = S_INS_RD;
                                end
                            end
                            KIND_FINISH:
                            begin
                                if (stat.bad_sender)
                                begin
                                    cmd.act = ACT_NOTHING;
                                end
                                else if (!stat.q_empty)
                                begin
                                    cmd.emit   = 1'b0;
                                    state_next = S_POP_RD;
                                end
                                else
                                begin
                                    cmd.busy_clear = 1'b1;
                                    if (!stat.busy_after_clear)
                                    begin
                                        cmd.stop_set = 1'b1;
                                        cmd.act      = ACT_QUIT;
                                    end
                                end
                            end
                            KIND_HALT:
                            begin
                                cmd.stop_set = 1'b1;
                                cmd.act      = ACT_HALTED;
                            end
                            default:
                            begin
                                cmd.act = ACT_NOTHING;
                            end
                        endcase
                    end
                end
            end
            S_INS_RD:
            begin
                if (stat.ptr_zero)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                // move the lower entry up one place while the new job ranks below it
                if (stat.worse)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.ins_write = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.last      = 1'b1;
                    cmd.act       = ACT_QUEUED;
                    cmd.pay       = PAY_IN;
                    state_next    = S_IDLE;
                end
            end
            S_POP_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_tail = 1'b1;
                state_next  = S_POP_EMIT;
            end
            S_POP_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.pop         = 1'b1;
                    cmd.busy_set    = 1'b1;
                    cmd.tgt_sender  = (stat.kind == KIND_FINISH);
                    cmd.emit        = 1'b1;
                    cmd.with_target = 1'b1;
                    cmd.act         = ACT_ASSIGN;
                    cmd.pay         = PAY_RAM;
                    if (stat.kind == KIND_DIST && stat.more)
                    begin
                        cmd.n_inc  = 1'b1;
                        state_next = S_POP_RD;
                    end
                    else
                    begin
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* src/priority_work_dispatcher_unit.sv */
// work dispatcher for a worker pool: busy bits, a sorted job queue and result sequencing
// usage:
//   in_ch carries one request (kind, sender_id, job_key, job_handle) at a time;
//   out_ch returns one or more results per request, the final one marked by last.
//   cfg_we/cfg_wdata write serve_order (0 largest key first, 1 smallest first);
//   write it only while no request is in flight.
// sequencing:
//   a request is taken in the idle state and decoded in the decode state, where it
//   waits while the output register is still full.
//   a queued job walks the insertion point down through the queue memory, with a
//   read and a compare state per entry moved, and is written in the write state
//   when the walk reaches the bottom of the queue or stops on a better entry.
//   each queue pop takes a memory read state and an emit state: a finished or
//   distribute request passes through both for each assignment it makes.
// reset clears all busy bits, the queue count, the stopped flag and serve_order;
// the queue memory itself is not cleared, as only entries below the count are read.
// when the receiver stalls, one result waits in the output register and the
// block holds its next result (and its state change) until that one is taken.
// depends on pwd_pkg, pwd_if, pwd_ram, pwd_datapath and pwd_ctrl
`timescale 1ns / 1ps
`default_nettype none

module priority_work_dispatcher_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    pwd_in_if.sink     in_ch,
    pwd_out_if.source  out_ch
);
    import pwd_pkg::*;

    pwd_cmd_t  cmd;
    pwd_stat_t stat;

    pwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pwd_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_kind           (in_ch.kind),
        .in_sender_id      (in_ch.sender_id),
        .in_job_key        (in_ch.job_key),
        .in_job_handle     (in_ch.job_handle),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .out_action        (out_ch.action),
        .out_target_worker (out_ch.target_worker),
        .out_key           (out_ch.out_key),
        .out_handle        (out_ch.out_handle),
        .out_queue_fill    (out_ch.queue_fill),
        .out_last          (out_ch.last)
    );

endmodule

`default_nettype wire

/* sim/tb_priority_work_dispatcher_unit.sv */
// self-checking testbench for priority_work_dispatcher_unit: directed and random requests,
// a cycle-free prediction of every result, random stalls on both channels
// depends on pwd_pkg, pwd_if and the dispatcher rtl
`timescale 1ns / 1ps

module tb_priority_work_dispatcher_unit;
    import pwd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
    localparam int ID_MAX          = (1 << ID_W) - 1;
    localparam int HANDLE_MAX      = (1 << HANDLE_WIDTH) - 1;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int IDLE_WAIT_LIMIT = 50000;
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_ITEMS     = 55;
    localparam int MAX_REPORTS     = 10;
    localparam int RUN_LIMIT_NS    = 10_000_000;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [ID_W-1:0]         target;
        logic [KEY_W-1:0]        key;
        logic [HANDLE_WIDTH-1:0] handle;
        logic [FILL_W-1:0]       fill;
        logic                    last;
    } dispatch_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    pwd_in_if  in_ch ();
    pwd_out_if out_ch ();

    priority_work_dispatcher_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // scheduler state as the dispatcher should hold it
    logic [NUM_WORKERS-1:0]  model_busy;
    logic [KEY_W-1:0]        model_keys [QUEUE_DEPTH];
    logic [HANDLE_WIDTH-1:0] model_handles [QUEUE_DEPTH];
    int                      model_count;
    bit                      model_stopped;
    bit                      model_order;

    dispatch_result_t pending_results[$];
    dispatch_result_t batch_res [MAX_RESULTS];
    int               batch_n;

    int fail_count;
    bit idle_en;
    bit hold_off_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic record_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    function automatic void emit_result(input logic [ACT_W-1:0] act, input int tgt,
                                        input logic [KEY_W-1:0] key,
                                        input logic [HANDLE_WIDTH-1:0] handle);
        batch_res[batch_n].action = act;
        batch_res[batch_n].target = tgt[ID_W-1:0];
        batch_res[batch_n].key    = key;
        batch_res[batch_n].handle = handle;
        batch_res[batch_n].fill   = model_count[FILL_W-1:0];
        batch_res[batch_n].last   = 1'b0;
        batch_n++;
    endfunction

    function automatic int first_idle_worker();
        for (int w = 0; w < NUM_WORKERS; w++)
            if (!model_busy[w])
                return w + 1;
        return 0;
    endfunction

    function automatic int pick_busy_worker();
        int start;
        int w;
        start = $urandom_range(0, NUM_WORKERS - 1);
        for (int i = 0; i < NUM_WORKERS; i++)
        begin
            w = (start + i) % NUM_WORKERS;
            if (model_busy[w])
                return w + 1;
        end
        return 0;
    endfunction

    // sorted insert, tail entry is the next one served
    function automatic bit queue_insert_job(input logic [KEY_W-1:0] key,
                                            input logic [HANDLE_WIDTH-1:0] handle);
        int i;
        bit moving;
        bit worse;
        if (model_count >= QUEUE_DEPTH)
            return 1'b0;
        i = model_count;
        moving = 1'b1;
        while (i > 0 && moving)
        begin
            worse = model_order ? (key > model_keys[i-1]) : (key < model_keys[i-1]);
            if (worse)
            begin
                model_keys[i]    = model_keys[i-1];
                model_handles[i] = model_handles[i-1];
                i--;
            end
            else
                moving = 1'b0;
        end
        model_keys[i]    = key;
        model_handles[i] = handle;
        model_count++;
        return 1'b1;
    endfunction

    function automatic void predict_dispatch(input logic [KIND_W-1:0] kind,
                                             input logic [ID_W-1:0] id,
                                             input logic [KEY_W-1:0] key,
                                             input logic [HANDLE_WIDTH-1:0] handle);
        int w;
        batch_n = 0;
        if (model_stopped)
            emit_result(ACT_NOTHING, 0, '0, '0);
        else if (kind == KIND_SUBMIT)
        begin
            if (queue_insert_job(key, handle))
                emit_result(ACT_QUEUED, 0, key, handle);
            else
                emit_result(ACT_DROPPED, 0, key, handle);
        end
        else if (kind == KIND_DIST)
        begin
            w = first_idle_worker();
            while (batch_n < MAX_RESULTS && model_count > 0 && w != 0)
            begin
                model_count--;
                model_busy[w-1] = 1'b1;
                emit_result(ACT_ASSIGN, w, model_keys[model_count],
                            model_handles[model_count]);
                w = first_idle_worker();
            end
            if (batch_n == 0)
                emit_result(ACT_NOTHING, 0, '0, '0);
        end
        else if (kind == KIND_FORK)
        begin
            w = first_idle_worker();
            if (w != 0)
            begin
                model_busy[w-1] = 1'b1;
                emit_result(ACT_ASSIGN, w, key, handle);
            end
            else if (queue_insert_job(key, handle))
                emit_result(ACT_QUEUED, 0, key, handle);
            else
                emit_result(ACT_DROPPED, 0, key, handle);
        end
        else if (kind == KIND_FINISH)
        begin
            if (id == '0 || int'(id) > NUM_WORKERS)
                emit_result(ACT_NOTHING, 0, '0, '0);
            else if (model_count > 0)
            begin
                model_count--;
                model_busy[id-1] = 1'b1;
                emit_result(ACT_ASSIGN, int'(id), model_keys[model_count],
                            model_handles[model_count]);
            end
            else
            begin
                model_busy[id-1] = 1'b0;
                if (model_busy == '0)
                begin
                    model_stopped = 1'b1;
                    emit_result(ACT_QUIT, 0, '0, '0);
                end
                else
                    emit_result(ACT_NOTHING, 0, '0, '0);
            end
        end
        else if (kind == KIND_HALT)
        begin
            model_stopped = 1'b1;
            emit_result(ACT_HALTED, 0, '0, '0);
        end
        else
            emit_result(ACT_NOTHING, 0, '0, '0);

        batch_res[batch_n-1].last = 1'b1;
        for (int i = 0; i < batch_n; i++)
            pending_results.push_back(batch_res[i]);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom_range(0, 15);
        if (pick == 4)
            return '0;
        if (pick == 5)
            return '1;
        return $urandom;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                input logic [KEY_W-1:0] key,
                                input logic [HANDLE_WIDTH-1:0] handle);
        int gap;
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.sender_id  <= id;
        in_ch.job_key    <= key;
        in_ch.job_handle <= handle;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_dispatch(kind, id, key, handle);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random_request();
        int pick;
        int id;
        logic [KIND_W-1:0] kind;
        logic [NUM_WORKERS-1:0] others;
        pick = $urandom_range(0, 99);
        id = $urandom_range(0, ID_MAX);
        if (pick < 25)
            kind = KIND_SUBMIT;
        else if (pick < 35)
            kind = KIND_DIST;
        else if (pick < 55)
            kind = KIND_FORK;
        else if (pick < 92)
        begin
            kind = KIND_FINISH;
            id = pick_busy_worker();
            if (id == 0 || $urandom_range(0, 4) == 0)
                id = $urandom_range(1, NUM_WORKERS);
        end
        else if (pick < 96)
        begin
            kind = KIND_FINISH;
            id = $urandom_range(0, 1) ? 0 : $urandom_range(NUM_WORKERS + 1, ID_MAX);
        end
        else
            kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        // the pool must stay alive until the wind-down, so a finish that would quit forks
        if (kind == KIND_FINISH && id >= 1 && id <= NUM_WORKERS && model_count == 0)
        begin
            others = model_busy;
            others[id-1] = 1'b0;
            if (others == '0)
                kind = KIND_FORK;
        end
        send_request(kind, id[ID_W-1:0], random_key(),
                     HANDLE_WIDTH'($urandom_range(0, HANDLE_MAX)));
    endtask

    task automatic wait_idle(input int limit);
        int waited;
        waited = 0;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_serve_order(input bit value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        model_order = value;
    endtask

    // fill the queue from an idle pool, then hand out the maximum in one go
    task automatic test_distribute_burst();
        send_request(KIND_SUBMIT, 5'd0, 32'h0000_0000, 16'h0000);
        send_request(KIND_SUBMIT, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(KIND_SUBMIT, 5'd1, 32'd5, 16'h0001);
        send_request(KIND_SUBMIT, 5'd2, 32'd5, 16'h0002);
        send_request(KIND_SUBMIT, 5'd4, 32'd5, 16'h0003);
        send_request(KIND_SUBMIT, 5'd8, 32'h8000_0000, 16'h8000);
        send_request(KIND_SUBMIT, 5'd16, 32'h7FFF_FFFF, 16'h7FFF);
        send_request(KIND_SUBMIT, 5'd0, 32'd1, 16'hAAAA);
        send_request(KIND_SUBMIT, 5'd0, 32'hFFFF_FFFE, 16'h5555);
        send_request(KIND_SUBMIT, 5'd0, 32'h0000_0000, 16'h0001);
        for (int i = 0; i < 7; i++)
            send_request(KIND_SUBMIT, ID_W'($urandom_range(0, ID_MAX)), random_key(),
                         HANDLE_WIDTH'($urandom_range(0, HANDLE_MAX)));
        send_request(KIND_DIST, 5'd0, '0, '0);
        // every worker busy now, so the fork is queued
        send_request(KIND_FORK, 5'd9, 32'd42, 16'h1234);
        send_request(KIND_FINISH, 5'd0, '0, '0);
        send_request(KIND_FINISH, 5'd31, '0, '0);
        send_request(KIND_UNUSED_LO, 5'd3, 32'd7, 16'h0007);
        send_request(KIND_UNUSED_HI, 5'd3, 32'd7, 16'h0007);
        send_request(KIND_FINISH, 5'd3, '0, '0);
        send_request(KIND_DIST, 5'd0, '0, '0);
        wait_idle(IDLE_WAIT_LIMIT);
    endtask

    task automatic test_queue_overflow();
        int drops;
        drops = 0;
        write_serve_order(1'b1);
        while (drops < 3)
        begin
            if (model_count == QUEUE_DEPTH)
            begin
                drops++;
                send_request((drops == 2) ? KIND_FORK : KIND_SUBMIT,
                             ID_W'($urandom_range(0, ID_MAX)), $urandom_range(0, 15),
                             HANDLE_WIDTH'($urandom_range(0, HANDLE_MAX)));
            end
            else
                send_request(KIND_SUBMIT, ID_W'($urandom_range(0, ID_MAX)),
                             $urandom_range(0, 15),
                             HANDLE_WIDTH'($urandom_range(0, HANDLE_MAX)));
        end
        wait_idle(IDLE_WAIT_LIMIT);
    endtask

    // result side holds off long enough for the request side to back up
    task automatic test_output_stall();
        hold_off_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_random_request();
        wait_idle(IDLE_WAIT_LIMIT);
    endtask

    task automatic test_serve_order_phases();
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 0)
                write_serve_order(1'b0);
            else if (p == 1)
                write_serve_order(1'b1);
            else
                write_serve_order(1'($urandom_range(0, 1)));
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_request();
            wait_idle(IDLE_WAIT_LIMIT);
        end
    endtask

    // no idling from here on; the run ends by quit or by halt, then stopped requests
    task automatic test_wind_down();
        int w;
        idle_en = 1'b0;
        for (int i = 0; i < 40; i++)
            send_random_request();
        if ($urandom_range(0, 1))
        begin
            while (!model_stopped)
            begin
                w = pick_busy_worker();
                if (w == 0)
                    w = 1;
                send_request(KIND_FINISH, ID_W'(w), $urandom,
                             HANDLE_WIDTH'($urandom_range(0, HANDLE_MAX)));
            end
        end
        else
            send_request(KIND_HALT, ID_W'($urandom_range(0, ID_MAX)), $urandom,
                         HANDLE_WIDTH'($urandom_range(0, HANDLE_MAX)));
        for (int k = 0; k <= int'(KIND_UNUSED_HI); k++)
            send_request(KIND_W'(k), ID_W'($urandom_range(0, ID_MAX)), $urandom,
                         HANDLE_WIDTH'($urandom_range(0, HANDLE_MAX)));
        wait_idle(IDLE_WAIT_LIMIT);
    endtask

    initial
    begin : result_ready_proc
        out_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin : result_checker
        dispatch_result_t got;
        dispatch_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.action = out_ch.action;
                got.target = out_ch.target_worker;
                got.key    = out_ch.out_key;
                got.handle = out_ch.out_handle;
                got.fill   = out_ch.queue_fill;
                got.last   = out_ch.last;
                if (pending_results.size() == 0)
                    record_failure($sformatf(
                        "unexpected result: act=%0d tgt=%0d key=%h hnd=%h fill=%0d last=%0d",
                        got.action, got.target, got.key, got.handle, got.fill, got.last));
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        record_failure($sformatf({"result mismatch at %0t:",
                            " expected act=%0d tgt=%0d key=%h hnd=%h fill=%0d last=%0d,",
                            " got act=%0d tgt=%0d key=%h hnd=%h fill=%0d last=%0d"},
                            $time, want.action, want.target, want.key, want.handle,
                            want.fill, want.last, got.action, got.target, got.key,
                            got.handle, got.fill, got.last));
                end
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= '0;
        in_ch.sender_id  <= '0;
        in_ch.job_key    <= '0;
        in_ch.job_handle <= '0;
        model_busy        = '0;
        model_count       = 0;
        model_stopped     = 1'b0;
        model_order       = 1'b0;
        fail_count        = 0;
        idle_en           = 1'b1;
        hold_off_req      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_distribute_burst();
        test_queue_overflow();
        test_output_stall();
        test_serve_order_phases();
        test_wind_down();

        if (pending_results.size() != 0)
            record_failure($sformatf("%0d expected results never arrived",
                                     pending_results.size()));
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
